// File: src/wpr_pkg.sv
// Package for the two-sensor wall pose reset block.
// Holds the register file type, pipeline sideband type, wall codes and
// CORDIC/conversion constants. No dependencies.
package wpr_pkg;

    localparam int FRAC_BITS = 8;

    // mm -> 2^-FRAC_BITS inch: floor((5*2^F*mm + 63) / 127), split as
    // MUL_Q*mm + floor((MUL_R*mm + 63) / 127).
    localparam int MUL_Q      = (5 << FRAC_BITS) / 127;
    localparam int MUL_R      = (5 << FRAC_BITS) % 127;
    localparam int RCP_SHIFT  = 27;
    localparam int RECIP127   = (1 << RCP_SHIFT) / 127 + 1;

    // Whole degrees modulo 360 through a reciprocal.
    localparam int DEG_OFFSET = 360 * 92;
    localparam int RCP_SHIFT_D = 26;
    localparam int RECIP360   = (1 << RCP_SHIFT_D) / 360 + 1;

    localparam int CORDIC_ITERS = 20;
    localparam int GUARD_BITS   = 12;
    localparam int CW           = 36;
    localparam int ZW           = 25;
    localparam int KINV_Q16     = 39797;
    localparam int FULL_TURN    = 360 * 256;
    localparam int MAX_ANGLE    = 90 * 256;
    localparam int HALF_TURN    = 180 * 256;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
        25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229,
        25'sd115, 25'sd57, 25'sd29, 25'sd14, 25'sd7
    };

    typedef enum logic [1:0] {
        WALL_TOP    = 2'd0,
        WALL_RIGHT  = 2'd1,
        WALL_BOTTOM = 2'd2,
        WALL_LEFT   = 2'd3
    } t_wall;

    typedef enum logic [2:0] {
        REG_BASELINE  = 3'd0,
        REG_LEFT_MNT  = 3'd1,
        REG_RIGHT_MNT = 3'd2,
        REG_HALF_FLD  = 3'd3,
        REG_MAX_READ  = 3'd4,
        REG_LEFT_BIAS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] sensor_baseline;
        logic [15:0] left_mount_depth;
        logic [15:0] right_mount_depth;
        logic [17:0] half_field_width;
        logic [17:0] max_valid_reading;
        logic [7:0]  left_bias_mm;
    } t_cfg;

    // Sideband that travels with each transaction through the pipeline.
    typedef struct packed {
        logic               upd;
        logic               byp;
        t_wall              wall;
        logic [20:0]        sum;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] ch;
    } t_side;

    function automatic logic signed [17:0] perp_of(input t_wall w);
        logic signed [17:0] p;
        begin
            case (w)
                WALL_TOP:    p = 18'sd46080;
                WALL_RIGHT:  p = 18'sd69120;
                WALL_BOTTOM: p = 18'sd0;
                WALL_LEFT:   p = 18'sd23040;
                default:     p = 18'sd0;
            endcase
            return p;
        end
    endfunction

endpackage

// File: src/wall_pose_reset_two_sensor.sv
// Two-sensor wall pose reset: top level with APB register file and stream ports.
// Depends on wpr_pkg, wpr_front, wpr_cordic and wpr_back.
// Pipeline: 3 front, 20 CORDIC and 3 back register stages from input to result.
// Throughput: one transaction per cycle; every stage advances together whenever
// the output register is empty or being drained.
// Reset (synchronous, active low) clears all stage valid bits and loads the
// register defaults; no clearing pass is needed.
module wall_pose_reset_two_sensor
    import wpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] left_distance_mm, [31:16] right_distance_mm, [55:32] current_x,
    // [79:56] current_y, [103:80] current_heading
    input  logic [103:0] s_axis_tdata,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] new_x, [47:24] new_y, [71:48] new_heading, [73:72] wall_chosen,
    // [89:74] wall_tilt, [95:90] zero
    output logic [95:0]  m_axis_tdata,
    // [0] update_valid
    output logic [0:0]   m_axis_tuser
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_en;

    logic                 f_valid;
    t_side                f_side;
    logic signed [CW-1:0] f_x, f_y, f_u;
    logic                 c_valid;
    t_side                c_side;
    logic signed [CW-1:0] c_u;
    logic signed [ZW-1:0] c_z;

    logic               b_valid, b_upd;
    logic signed [23:0] b_x, b_y, b_hd;
    t_wall              b_wall;
    logic signed [15:0] b_ang;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;

    // register file: write on the access cycle, ignore addresses past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_baseline   <= 16'd2688;
            r_cfg.left_mount_depth  <= 16'd1248;
            r_cfg.right_mount_depth <= 16'd1248;
            r_cfg.half_field_width  <= 18'd18432;
            r_cfg.max_valid_reading <= 18'd51200;
            r_cfg.left_bias_mm      <= 8'd19;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_BASELINE:  r_cfg.sensor_baseline   <= pwdata[15:0];
                REG_LEFT_MNT:  r_cfg.left_mount_depth  <= pwdata[15:0];
                REG_RIGHT_MNT: r_cfg.right_mount_depth <= pwdata[15:0];
                REG_HALF_FLD:  r_cfg.half_field_width  <= pwdata[17:0];
                REG_MAX_READ:  r_cfg.max_valid_reading <= pwdata[17:0];
                REG_LEFT_BIAS: r_cfg.left_bias_mm      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BASELINE:  prdata = {16'd0, r_cfg.sensor_baseline};
            REG_LEFT_MNT:  prdata = {16'd0, r_cfg.left_mount_depth};
            REG_RIGHT_MNT: prdata = {16'd0, r_cfg.right_mount_depth};
            REG_HALF_FLD:  prdata = {14'd0, r_cfg.half_field_width};
            REG_MAX_READ:  prdata = {14'd0, r_cfg.max_valid_reading};
            REG_LEFT_BIAS: prdata = {24'd0, r_cfg.left_bias_mm};
            default:       prdata = 32'd0;
        endcase
    end

    // Advance the whole pipeline when the output register is free or drains;
    // hold every stage otherwise so nothing is lost or repeated.
    assign w_en          = !b_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    wpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_left  (s_axis_tdata[15:0]),
        .i_right (s_axis_tdata[31:16]),
        .i_cx    (s_axis_tdata[55:32]),
        .i_cy    (s_axis_tdata[79:56]),
        .i_ch    (s_axis_tdata[103:80]),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_u     (f_u)
    );

    wpr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_x     (f_x),
        .i_y     (f_y),
        .i_u     (f_u),
        .o_valid (c_valid),
        .o_side  (c_side),
        .o_u     (c_u),
        .o_z     (c_z)
    );

    wpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (c_valid),
        .i_side  (c_side),
        .i_u     (c_u),
        .i_z     (c_z),
        .i_cfg   (r_cfg),
        .o_valid (b_valid),
        .o_upd   (b_upd),
        .o_x     (b_x),
        .o_y     (b_y),
        .o_hd    (b_hd),
        .o_wall  (b_wall),
        .o_ang   (b_ang)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {6'd0, b_ang, b_wall, b_hd, b_y, b_x};
    assign m_axis_tuser  = b_upd;

    // the input side is stalled exactly when a result waits unclaimed
    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // a rejected reading leaves wall and angle at zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (b_wall == WALL_TOP && b_ang == 16'sd0))
        else $error("rejected result carries wall or angle");

    // an accepted reading gives a wrapped heading and a clamped angle
    a_update_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (b_hd >= 24'sd0 && b_hd < 24'sd92160 && b_ang <= 16'sd23040
         && b_ang >= -16'sd23040))
        else $error("corrected heading or angle out of range");

endmodule

// File: src/wpr_front.sv
// Front end: mm to fixed-point conversion, range check, wall selection and
// CORDIC operand setup. Three register stages. Depends on wpr_pkg.
module wpr_front
    import wpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [15:0]        i_left,
    input  logic [15:0]        i_right,
    input  logic signed [23:0] i_cx,
    input  logic signed [23:0] i_cy,
    input  logic signed [23:0] i_ch,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output t_side              o_side,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_u
);

    // stage 1
    logic [16:0] n_mm_l, n_mm_r;
    logic [19:0] w_xl, w_xr;
    logic [40:0] w_pl, w_pr;
    logic signed [24:0] w_back, w_back_adj;
    logic signed [16:0] w_deg;
    logic signed [17:0] w_t;
    t_side       n_s1;
    logic        r_v1;
    logic [16:0] r_mm_l, r_mm_r;
    logic [12:0] r_q_l, r_q_r;
    logic [16:0] r_t1;
    t_side       r_s1;

    // stage 2
    logic [19:0] w_dl, w_dr;
    logic [34:0] w_pd;
    t_side       n_s2;
    logic        r_v2;
    logic signed [20:0] r_diff;
    logic [20:0] r_sum;
    logic [16:0] r_t2;
    logic [7:0]  r_qh;
    t_side       r_s2;

    // stage 3
    logic [8:0]  w_rem;
    t_wall       w_wall;
    t_side       n_s3;
    logic        r_v3;
    t_side       r_s3;
    logic signed [CW-1:0] r_x, r_y, r_u;

    always_comb begin
        n_mm_l = {1'b0, i_left} + {9'd0, i_cfg.left_bias_mm};
        n_mm_r = {1'b0, i_right};
        w_xl   = 20'(n_mm_l) * 20'(MUL_R) + 20'd63;
        w_xr   = 20'(n_mm_r) * 20'(MUL_R) + 20'd63;
        w_pl   = 41'(w_xl) * 41'(RECIP127);
        w_pr   = 41'(w_xr) * 41'(RECIP127);
        // truncate the rear heading toward zero in whole degrees
        w_back = $signed({i_ch[23], i_ch}) + 25'sd46080;
        w_back_adj = w_back[24] ? (w_back + 25'sd255) : w_back;
        w_deg  = w_back_adj[24:8];
        w_t    = $signed({w_deg[16], w_deg}) + 18'sd33120;
        n_s1    = '0;
        n_s1.cx = i_cx;
        n_s1.cy = i_cy;
        n_s1.ch = i_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mm_l   <= n_mm_l;
            r_mm_r   <= n_mm_r;
            r_q_l    <= w_pl[RCP_SHIFT+12:RCP_SHIFT];
            r_q_r    <= w_pr[RCP_SHIFT+12:RCP_SHIFT];
            r_t1     <= w_t[16:0];
            r_s1     <= n_s1;
        end
    end

    always_comb begin
        w_dl = 20'(r_mm_l) * 20'(MUL_Q) + {7'd0, r_q_l};
        w_dr = 20'(r_mm_r) * 20'(MUL_Q) + {7'd0, r_q_r};
        w_pd = 35'(r_t1) * 35'(RECIP360);
        n_s2     = r_s1;
        n_s2.upd = (w_dl <= {2'd0, i_cfg.max_valid_reading})
                && (w_dr <= {2'd0, i_cfg.max_valid_reading});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff   <= $signed({1'b0, w_dr}) - $signed({1'b0, w_dl});
            r_sum    <= {1'b0, w_dl} + {1'b0, w_dr};
            r_t2     <= r_t1;
            r_qh     <= w_pd[RCP_SHIFT_D+7:RCP_SHIFT_D];
            r_s2     <= n_s2;
        end
    end

    always_comb begin
        w_rem = 9'(r_t2 - 17'(r_qh) * 17'd360);
        if (w_rem >= 9'd315 || w_rem <= 9'd45) begin
            w_wall = WALL_TOP;
        end else if (w_rem <= 9'd135) begin
            w_wall = WALL_RIGHT;
        end else if (w_rem <= 9'd225) begin
            w_wall = WALL_BOTTOM;
        end else begin
            w_wall = WALL_LEFT;
        end
        n_s3      = r_s2;
        n_s3.wall = w_wall;
        n_s3.sum  = r_sum;
        n_s3.byp  = (i_cfg.sensor_baseline == 16'd0) && (r_diff == 21'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3      <= n_s3;
            r_x       <= $signed({8'd0, i_cfg.sensor_baseline, 12'd0});
            r_y       <= $signed({{3{r_diff[20]}}, r_diff, 12'd0});
            r_u       <= $signed({3'd0, r_sum, 12'd0});
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_s3;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_u     = r_u;

endmodule

// File: src/wpr_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, with a second
// vector rotated alongside. Depends on wpr_pkg.
module wpr_cordic
    import wpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_u,
    output logic               o_valid,
    output t_side              o_side,
    output logic signed [CW-1:0] o_u,
    output logic signed [ZW-1:0] o_z
);

    logic signed [CW-1:0] w_x [CORDIC_ITERS+1];
    logic signed [CW-1:0] w_y [CORDIC_ITERS+1];
    logic signed [CW-1:0] w_u [CORDIC_ITERS+1];
    logic signed [CW-1:0] w_v [CORDIC_ITERS+1];
    logic signed [ZW-1:0] w_z [CORDIC_ITERS+1];
    logic                 w_vl [CORDIC_ITERS+1];
    t_side                w_s [CORDIC_ITERS+1];

    assign w_x[0]  = i_x;
    assign w_y[0]  = i_y;
    assign w_u[0]  = i_u;
    assign w_v[0]  = '0;
    assign w_z[0]  = '0;
    assign w_vl[0] = i_valid;
    assign w_s[0]  = i_side;

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_stage
        logic signed [CW-1:0] r_x, r_y, r_u, r_v;
        logic signed [ZW-1:0] r_z;
        logic                 r_vl;
        t_side                r_s;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl <= 1'b0;
            end else if (i_en) begin
                r_vl <= w_vl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s <= w_s[k];
                if (!w_y[k][CW-1]) begin
                    r_x <= w_x[k] + (w_y[k] >>> k);
                    r_y <= w_y[k] - (w_x[k] >>> k);
                    r_u <= w_u[k] + (w_v[k] >>> k);
                    r_v <= w_v[k] - (w_u[k] >>> k);
                    r_z <= w_z[k] + ATAN_TAB[k];
                end else begin
                    r_x <= w_x[k] - (w_y[k] >>> k);
                    r_y <= w_y[k] + (w_x[k] >>> k);
                    r_u <= w_u[k] - (w_v[k] >>> k);
                    r_v <= w_v[k] + (w_u[k] >>> k);
                    r_z <= w_z[k] - ATAN_TAB[k];
                end
            end
        end

        assign w_x[k+1]  = r_x;
        assign w_y[k+1]  = r_y;
        assign w_u[k+1]  = r_u;
        assign w_v[k+1]  = r_v;
        assign w_z[k+1]  = r_z;
        assign w_vl[k+1] = r_vl;
        assign w_s[k+1]  = r_s;
    end

    assign o_valid = w_vl[CORDIC_ITERS];
    assign o_side  = w_s[CORDIC_ITERS];
    assign o_u     = w_u[CORDIC_ITERS];
    assign o_z     = w_z[CORDIC_ITERS];

endmodule

// File: src/wpr_back.sv
// Back end: gain correction, angle rounding, distance, pose and heading,
// ending in the output register. Three register stages. Depends on wpr_pkg.
module wpr_back
    import wpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic signed [CW-1:0] i_u,
    input  logic signed [ZW-1:0] i_z,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic               o_upd,
    output logic signed [23:0] o_x,
    output logic signed [23:0] o_y,
    output logic signed [23:0] o_hd,
    output t_wall              o_wall,
    output logic signed [15:0] o_ang
);

    logic signed [ZW-1:0] w_za;
    logic signed [15:0]   w_ang;
    logic                 r_v1, r_v2, r_v3;
    logic signed [52:0]   r_prod;
    logic signed [15:0]   r_ang1, r_ang2;
    t_side                r_s1, r_s2;

    logic signed [52:0]   w_rnd, w_sc;
    logic [21:0]          w_sumcos;
    logic [21:0]          r_sc;

    logic [22:0]          w_dsum;
    logic [21:0]          w_dist;
    logic signed [24:0]   w_span, w_pos;
    logic signed [17:0]   w_hd0, w_hd;

    logic                 r_upd;
    logic signed [23:0]   r_x, r_y, r_hd;
    t_wall                r_wall;
    logic signed [15:0]   r_ang3;

    always_comb begin
        w_za = (i_z + 25'sd128) >>> 8;
        if (i_side.byp) begin
            w_ang = '0;
        end else if (w_za > 25'sd23040) begin
            w_ang = 16'sd23040;
        end else if (w_za < -25'sd23040) begin
            w_ang = -16'sd23040;
        end else begin
            w_ang = w_za[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 53'(i_u) * 53'sd39797;
            r_ang1 <= w_ang;
            r_s1   <= i_side;
        end
    end

    // undo the CORDIC gain and drop the guard bits, rounding halves up
    always_comb begin
        w_rnd = (r_prod >>> 16) + 53'sd2048;
        w_sc  = w_rnd >>> GUARD_BITS;
        if (r_s1.byp) begin
            w_sumcos = {1'b0, r_s1.sum};
        end else if (w_sc[52]) begin
            w_sumcos = '0;
        end else begin
            w_sumcos = w_sc[21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc   <= w_sumcos;
            r_ang2 <= r_ang1;
            r_s2   <= r_s1;
        end
    end

    always_comb begin
        w_dsum = {1'b0, r_sc} + {7'd0, i_cfg.left_mount_depth}
               + {7'd0, i_cfg.right_mount_depth} + 23'd1;
        w_dist = w_dsum[22:1];
        w_span = $signed({7'd0, i_cfg.half_field_width}) - $signed({3'd0, w_dist});
        w_pos  = r_s2.wall[1] ? -w_span : w_span;
        w_hd0  = perp_of(r_s2.wall) - 18'(r_ang2);
        if (w_hd0 < 18'sd0) begin
            w_hd = w_hd0 + 18'sd92160;
        end else if (w_hd0 >= 18'sd92160) begin
            w_hd = w_hd0 - 18'sd92160;
        end else begin
            w_hd = w_hd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_upd <= r_s2.upd;
            if (r_s2.upd) begin
                r_x    <= r_s2.wall[0] ? w_pos[23:0] : r_s2.cx;
                r_y    <= r_s2.wall[0] ? r_s2.cy : w_pos[23:0];
                r_hd   <= 24'(w_hd);
                r_wall <= r_s2.wall;
                r_ang3 <= r_ang2;
            end else begin
                r_x    <= r_s2.cx;
                r_y    <= r_s2.cy;
                r_hd   <= r_s2.ch;
                r_wall <= WALL_TOP;
                r_ang3 <= '0;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_upd   = r_upd;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_hd    = r_hd;
    assign o_wall  = r_wall;
    assign o_ang   = r_ang3;

endmodule

// File: test/wpr_checker.sv
// Result checker for the two-sensor wall pose reset block.
// Watches both stream channels and the APB port, predicts each result, and compares.
// Depends on wpr_pkg.
`timescale 1ns / 100ps
module wpr_checker
    import wpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_results,
    output int           o_corrected
);

    typedef struct packed {
        logic        upd;
        logic [95:0] data;
    } t_pose_out;

    localparam longint ATAN_Q16 [20] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    t_cfg      cfg_q;
    t_pose_out pose_q[$];

    assign o_pending = pose_q.size();

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mm_to_in(longint mm);
        return ((mm * 10) * 256 + 127) / 254;
    endfunction

    function automatic t_pose_out predict_pose(logic [103:0] d);
        t_pose_out r;
        longint cx, cy, ch, dl, dr, dif, sm, z, sc, x, y, u, v, xs, ys, us, vs;
        longint ang, dist_in, span, deg, perp, pos, nx, ny, hd;
        t_wall wall;
        cx = longint'($signed(d[55:32]));
        cy = longint'($signed(d[79:56]));
        ch = longint'($signed(d[103:80]));
        dl = mm_to_in(longint'(d[15:0]) + longint'(cfg_q.left_bias_mm));
        dr = mm_to_in(longint'(d[31:16]));
        r = '0;
        if (dl > cfg_q.max_valid_reading || dr > cfg_q.max_valid_reading) begin
            r.data = {24'd0, d[103:80], d[79:56], d[55:32]};
            return r;
        end
        dif = dr - dl;
        sm = dl + dr;
        z = 0;
        sc = sm;
        if (!(cfg_q.sensor_baseline == 0 && dif == 0)) begin
            x = longint'(cfg_q.sensor_baseline) <<< 12;
            y = dif <<< 12;
            u = sm <<< 12;
            v = 0;
            for (int i = 0; i < 20; i++) begin
                xs = shr_floor(x, i); ys = shr_floor(y, i);
                us = shr_floor(u, i); vs = shr_floor(v, i);
                if (y >= 0) begin
                    x += ys; y -= xs; u += vs; v -= us; z += ATAN_Q16[i];
                end else begin
                    x -= ys; y += xs; u -= vs; v += us; z -= ATAN_Q16[i];
                end
            end
            sc = shr_floor(shr_floor(u * 39797, 16) + 2048, 12);
            if (sc < 0) sc = 0;
        end
        ang = shr_floor(z + 128, 8);
        if (ang > 23040) ang = 23040;
        if (ang < -23040) ang = -23040;
        dist_in = (sc + cfg_q.left_mount_depth + cfg_q.right_mount_depth + 1) / 2;
        span = longint'(cfg_q.half_field_width) - dist_in;
        deg = (ch + 46080) / 256;           // truncates toward zero
        deg = ((deg % 360) + 360) % 360;
        if (deg >= 315 || deg <= 45) begin
            wall = WALL_TOP; perp = 180;
        end else if (deg <= 135) begin
            wall = WALL_RIGHT; perp = 270;
        end else if (deg <= 225) begin
            wall = WALL_BOTTOM; perp = 0;
        end else begin
            wall = WALL_LEFT; perp = 90;
        end
        pos = (wall == WALL_TOP || wall == WALL_RIGHT) ? span : -span;
        nx = (wall == WALL_RIGHT || wall == WALL_LEFT) ? pos : cx;
        ny = (wall == WALL_TOP || wall == WALL_BOTTOM) ? pos : cy;
        hd = perp * 256 - ang;
        hd = ((hd % 92160) + 92160) % 92160;
        r.upd = 1'b1;
        r.data = {6'd0, ang[15:0], wall, hd[23:0], ny[23:0], nx[23:0]};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] exp);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_pose_out e;
        if (!i_rst_n) begin
            cfg_q <= '{16'd2688, 16'd1248, 16'd1248, 18'd18432, 18'd51200, 8'd19};
            o_errors = 0;
            o_results = 0;
            o_corrected = 0;
        end else begin
            // results first: an input accepted now cannot leave in the same cycle
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                if (pose_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    e = pose_q.pop_front();
                    if (e.upd) o_corrected++;
                    if (m_axis_tuser[0] !== e.upd)
                        report_mismatch("update_valid", 96'(m_axis_tuser), 96'(e.upd));
                    if (m_axis_tdata[23:0] !== e.data[23:0])
                        report_mismatch("new_x", 96'(m_axis_tdata[23:0]), 96'(e.data[23:0]));
                    if (m_axis_tdata[47:24] !== e.data[47:24])
                        report_mismatch("new_y", 96'(m_axis_tdata[47:24]),
                                        96'(e.data[47:24]));
                    if (m_axis_tdata[71:48] !== e.data[71:48])
                        report_mismatch("new_heading", 96'(m_axis_tdata[71:48]),
                                        96'(e.data[71:48]));
                    if (m_axis_tdata[73:72] !== e.data[73:72])
                        report_mismatch("wall_chosen", 96'(m_axis_tdata[73:72]),
                                        96'(e.data[73:72]));
                    if (m_axis_tdata[95:74] !== e.data[95:74])
                        report_mismatch("wall_tilt", 96'(m_axis_tdata[95:74]),
                                        96'(e.data[95:74]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pose_q.push_back(predict_pose(s_axis_tdata));
            // register writes only happen while idle, so ordering vs. inputs is moot
            if (psel && penable && pwrite) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_BASELINE:  cfg_q.sensor_baseline   <= pwdata[15:0];
                    REG_LEFT_MNT:  cfg_q.left_mount_depth  <= pwdata[15:0];
                    REG_RIGHT_MNT: cfg_q.right_mount_depth <= pwdata[15:0];
                    REG_HALF_FLD:  cfg_q.half_field_width  <= pwdata[17:0];
                    REG_MAX_READ:  cfg_q.max_valid_reading <= pwdata[17:0];
                    REG_LEFT_BIAS: cfg_q.left_bias_mm      <= pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: test/tb_wall_pose_reset_two_sensor.sv
// Testbench top for the two-sensor wall pose reset block.
// Drives APB writes and the input stream, stalls the result stream, and gives the verdict.
// Depends on wpr_pkg, wpr_checker and the block itself.
`timescale 1ns / 100ps
module tb_wall_pose_reset_two_sensor;
    import wpr_pkg::*;

    localparam int LATENCY    = 26;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_ITEMS = 1850;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int  fail_count, pending_poses, result_count, corrected_count;
    int  quiet_cycles = 0;
    int  idle_pct = 35;        // idling percentage for both sides
    int  sent_count = 0;

    always #5 i_clk = ~i_clk;

    wall_pose_reset_two_sensor dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    wpr_checker pose_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_errors(fail_count), .o_pending(pending_poses),
        .o_results(result_count), .o_corrected(corrected_count)
    );

    // Randomly stall the result side.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX) begin
            $display("watchdog expired with %0d results pending", pending_poses);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Write one register: setup cycle, then access cycle.
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every expected result has arrived, then let the pipe empty.
    task automatic drain_poses();
        while (pending_poses != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Send one transaction, holding tvalid until accepted; idle gaps at random.
    task automatic send_pose(logic [15:0] lmm, logic [15:0] rmm,
                             logic [23:0] x, logic [23:0] y, logic [23:0] hdg);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hdg, y, x, rmm, lmm};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random heading: mostly near wall boundaries or anywhere, sometimes extreme.
    function automatic logic [23:0] pick_heading();
        int sel;
        int bnd;
        sel = $urandom_range(9);
        if (sel < 4) begin
            bnd = 256 * (45 + 90 * $urandom_range(3)) - 46080
                  + 92160 * ($urandom_range(4) - 2) + $urandom_range(1024) - 512;
            return 24'(bnd);
        end
        if (sel < 6) return 24'($urandom_range(92159));
        return 24'($urandom);
    endfunction

    // Random reading: mostly within 0..spread mm, some anywhere.
    function automatic logic [15:0] pick_mm(int spread);
        if ($urandom_range(9) < 8) return 16'($urandom_range(spread));
        return 16'($urandom);
    endfunction

    task automatic random_burst(int n, int spread);
        logic [15:0] l;
        for (int i = 0; i < n; i++) begin
            l = pick_mm(spread);
            // often keep the pair close so the angle stays moderate
            send_pose(l, ($urandom_range(1)) ? 16'(l + $urandom_range(200) - 100)
                                             : pick_mm(spread),
                      24'($urandom), 24'($urandom), pick_heading());
        end
        end_burst();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, range limit, every wall, equal readings.
        send_pose(16'd0, 16'd0, 24'h000000, 24'h000000, 24'h000000);
        send_pose(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_pose(16'd5061, 16'd5080, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_pose(16'd5062, 16'd5080, 24'h123456, 24'h654321, 24'd0);
        send_pose(16'd1000, 16'd5081, 24'h000100, 24'h000200, 24'd0);
        send_pose(16'd500, 16'd500, 24'd0, 24'd0, 24'd23040);
        send_pose(16'd500, 16'd600, 24'd0, 24'd0, 24'd46080);
        send_pose(16'd600, 16'd500, 24'd0, 24'd0, 24'd69120);
        send_pose(16'd300, 16'd900, 24'd0, 24'd0, -24'sd11520);
        send_pose(16'd1200, 16'd1200, 24'd5, 24'd5, 24'd34560);
        send_pose(16'd1200, 16'd1200, 24'd5, 24'd5, 24'd34816);
        send_pose(16'd1200, 16'd1200, 24'd5, 24'd5, -24'sd255);
        send_pose(16'd1200, 16'd1200, 24'd5, 24'd5, -24'sd46336);
        send_pose(16'd0, 16'd5080, 24'd7, 24'd9, 24'd92160);
        end_burst();
        drain_poses();

        // Zero baseline: degenerate vector and near-vertical angles.
        write_reg(REG_BASELINE, 32'd0);
        send_pose(16'd981, 16'd1000, 24'd0, 24'd0, 24'd0);
        send_pose(16'd100, 16'd3000, 24'd0, 24'd0, 24'd0);
        send_pose(16'd3000, 16'd100, 24'd0, 24'd0, 24'd46080);
        end_burst();
        random_burst(40, 5200);
        drain_poses();

        // Extremes of every register.
        write_reg(REG_BASELINE, 32'hFFFFFFFF);
        write_reg(REG_LEFT_MNT, 32'h0000FFFF);
        write_reg(REG_RIGHT_MNT, 32'h0000FFFF);
        write_reg(REG_HALF_FLD, 32'h0003FFFF);
        write_reg(REG_MAX_READ, 32'h0003FFFF);
        write_reg(REG_LEFT_BIAS, 32'h000000FF);
        send_pose(16'hFFFF, 16'd0, 24'd1, 24'd2, 24'd3);
        send_pose(16'd0, 16'hFFFF, 24'd1, 24'd2, 24'd3);
        end_burst();
        random_burst(200, 65535);
        drain_poses();

        write_reg(REG_LEFT_MNT, 32'd0);
        write_reg(REG_RIGHT_MNT, 32'd0);
        write_reg(REG_HALF_FLD, 32'd0);
        write_reg(REG_MAX_READ, 32'd0);
        write_reg(REG_LEFT_BIAS, 32'd0);
        write_reg(REG_BASELINE, 32'd1);
        random_burst(60, 40);
        drain_poses();

        // Back to typical values, then the long random part.
        write_reg(REG_BASELINE, 32'd2688);
        write_reg(REG_LEFT_MNT, 32'd1248);
        write_reg(REG_RIGHT_MNT, 32'd900);
        write_reg(REG_HALF_FLD, 32'd18432);
        write_reg(REG_MAX_READ, 32'd51200);
        write_reg(REG_LEFT_BIAS, 32'd19);
        random_burst(700, 5200);

        // Hold off until every result has come back, then continue.
        drain_poses();
        idle_pct = 0;            // a stretch with no idling on either side
        random_burst(300, 5200);
        idle_pct = 35;
        drain_poses();

        write_reg(REG_BASELINE, 32'd800);
        write_reg(REG_HALF_FLD, 32'd30000);
        write_reg(REG_LEFT_BIAS, 32'd128);
        random_burst(RAND_ITEMS - 1300, 5200);

        drain_poses();
        $display("sent %0d transactions, %0d results, %0d corrected poses",
                 sent_count, result_count, corrected_count);
        $display("covered register extremes, zero baseline, range limit and all four walls");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
src/wpr_pkg.sv
src/wpr_front.sv
src/wpr_cordic.sv
src/wpr_back.sv
src/wall_pose_reset_two_sensor.sv
test/wpr_checker.sv
test/tb_wall_pose_reset_two_sensor.sv
